// ===== rtl/core/sms_pkg.sv =====
// Shared types and codes for the stack machine step block.
// Used by sms_alu and stack_machine_step_top; no dependencies.
`default_nettype none

package sms_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [3:0] {
      CMD_HALT  = 4'd0,
      CMD_PUSH  = 4'd1,
      CMD_POP   = 4'd2,
      CMD_ADD   = 4'd3,
      CMD_SUB   = 4'd4,
      CMD_MUL   = 4'd5,
      CMD_DIV   = 4'd6,
      CMD_PRINT = 4'd7,
      CMD_SEND  = 4'd8,
      CMD_RECV  = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_EXEC   = 3'd0,
      KIND_PRINT  = 3'd1,
      KIND_SEND   = 3'd2,
      KIND_RECV   = 3'd3,
      KIND_HALT   = 3'd4,
      KIND_FAULT  = 3'd5,
      KIND_IGNORE = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

endpackage

`default_nettype wire

// ===== rtl/core/stack_machine_step_top.sv =====
// Stack machine step: one instruction per input word, one result word each.
// Halt, push, pop, send, recv, faults found at decode and stopped words
// answer from decode; print and divide by zero first read the top of stack;
// add, sub, mul and div read both operands and wait for the shared arithmetic
// unit, whose divide takes 32 restoring steps. One instruction at a time: the
// next word is taken in the cycle after the result is queued.
// Synchronous active-high reset: empty stack, running, no result pending.
// Depends on sms_pkg, sms_stack, sms_alu.
`default_nettype none

module stack_machine_step_top #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // command[3:0], immediate[35:4]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // kind[2:0], value[34:3], stack_depth[SP_W+34:35], is_running[SP_W+35]
   output logic [((36 + $clog2(STACK_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int unsigned W      = sms_pkg::DATA_W;
   localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
   localparam int unsigned OUT_W  = ((36 + SP_W + 7) / 8) * 8;
   localparam int unsigned VAL_LO = 3;
   localparam int unsigned SP_LO  = VAL_LO + W;
   localparam int unsigned RUN_B  = SP_LO + SP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDB,
      S_RDA,
      S_ALU,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              run_ff, run_in;
   sms_pkg::cmd_type  cmd_ff, cmd_in;
   logic [W-1:0]      imm_ff, imm_in;
   logic [W-1:0]      b_ff, b_in;
   sms_pkg::kind_type kind_ff, kind_in;
   logic [W-1:0]      value_ff, value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [W-1:0]      wr_data, rd_data;
   sms_pkg::alu_req_type alu_req;
   logic              alu_done;
   logic [W-1:0]      alu_result;
   logic              fault;
   logic [ADDR_W-1:0] top_addr, second_addr;

   sms_stack #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W),
      .WORD_W (W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sms_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a      (rd_data),
      .b      (b_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign top_addr    = sp_ff[ADDR_W-1:0] - ADDR_W'(1);
   assign second_addr = sp_ff[ADDR_W-1:0] - ADDR_W'(2);

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      run_in       = run_ff;
      cmd_in       = cmd_ff;
      imm_in       = imm_ff;
      b_in         = b_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = sp_ff[ADDR_W-1:0];
      wr_data      = imm_ff;
      rd_en        = 1'b0;
      rd_addr      = top_addr;
      alu_req      = '{start: 1'b0, op: sms_pkg::ALU_ADD};
      fault        = 1'b0;

      case (cmd_ff)
         sms_pkg::CMD_SUB: alu_req.op = sms_pkg::ALU_SUB;
         sms_pkg::CMD_MUL: alu_req.op = sms_pkg::ALU_MUL;
         sms_pkg::CMD_DIV: alu_req.op = sms_pkg::ALU_DIV;
         default:          alu_req.op = sms_pkg::ALU_ADD;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = sms_pkg::cmd_type'(req_tdata[3:0]);
               imm_in   = req_tdata[35:4];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            kind_in  = sms_pkg::KIND_EXEC;
            value_in = '0;
            state_in = S_OUT;
            if (!run_ff) begin
               kind_in = sms_pkg::KIND_IGNORE;
            end else begin
               case (cmd_ff)
                  sms_pkg::CMD_HALT: begin
                     run_in  = 1'b0;
                     kind_in = sms_pkg::KIND_HALT;
                  end
                  sms_pkg::CMD_PUSH: begin
                     if (sp_ff < SP_W'(STACK_DEPTH)) begin
                        wr_en = 1'b1;
                        sp_in = sp_ff + SP_W'(1);
                     end else begin
                        fault = 1'b1;
                     end
                  end
                  sms_pkg::CMD_POP: begin
                     if (sp_ff != '0) begin
                        sp_in = sp_ff - SP_W'(1);
                     end else begin
                        fault = 1'b1;
                     end
                  end
                  sms_pkg::CMD_ADD, sms_pkg::CMD_SUB,
                  sms_pkg::CMD_MUL, sms_pkg::CMD_DIV: begin
                     if (sp_ff < SP_W'(2)) begin
                        fault = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RDB;
                     end
                  end
                  sms_pkg::CMD_PRINT: begin
                     if (sp_ff != '0) begin
                        rd_en    = 1'b1;
                        state_in = S_RDB;
                     end else begin
                        fault = 1'b1;
                     end
                  end
                  sms_pkg::CMD_SEND: begin
                     kind_in  = sms_pkg::KIND_SEND;
                     value_in = imm_ff;
                  end
                  sms_pkg::CMD_RECV: begin
                     kind_in = sms_pkg::KIND_RECV;
                  end
                  default: begin
                     fault = 1'b1;
                  end
               endcase
            end
         end
         S_RDB: begin
            // top of stack word is on the read port now
            state_in = S_OUT;
            if (cmd_ff == sms_pkg::CMD_PRINT) begin
               kind_in  = sms_pkg::KIND_PRINT;
               value_in = rd_data;
            end else if (cmd_ff == sms_pkg::CMD_DIV && rd_data == '0) begin
               fault = 1'b1;
            end else begin
               b_in     = rd_data;
               rd_en    = 1'b1;
               rd_addr  = second_addr;
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            alu_req.start = 1'b1;
            state_in      = S_ALU;
         end
         S_ALU: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = second_addr;
               wr_data  = alu_result;
               sp_in    = sp_ff - SP_W'(1);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in                     = 1'b1;
               rsp_data_in                      = '0;
               rsp_data_in[2:0]                 = kind_ff;
               rsp_data_in[VAL_LO +: W]         = value_ff;
               rsp_data_in[SP_LO +: SP_W]       = sp_ff;
               rsp_data_in[RUN_B]               = run_ff;
               state_in                         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fault) begin
         run_in   = 1'b0;
         kind_in  = sms_pkg::KIND_FAULT;
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         run_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      imm_ff      <= imm_in;
      b_ff        <= b_in;
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_sp_in_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_stopped_frozen: assert property (@(posedge clock) disable iff (reset)
      !run_ff |=> ($stable(sp_ff) && !run_ff))
      else $error("stack changed or machine restarted while stopped");

   a_alu_done_state: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_ALU))
      else $error("divide/arith result outside of wait state");

   a_ignore_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_data_in[2:0] == sms_pkg::KIND_IGNORE)
         |-> !rsp_data_in[RUN_B])
      else $error("ignored word reported as running");

endmodule

`default_nettype wire

// ===== rtl/core/sms_stack.sv =====
// Operand stack storage: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sms_stack #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6,
   parameter int unsigned WORD_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sms_alu.sv =====
// Shared arithmetic unit: add, sub and mul, and signed divide by
// 32 restoring steps plus a sign fix. Depends on sms_pkg.
`default_nettype none

module sms_alu (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sms_pkg::alu_req_type      req,
   input  wire logic [sms_pkg::DATA_W-1:0] a,
   input  wire logic [sms_pkg::DATA_W-1:0] b,
   output logic                           done,
   output logic      [sms_pkg::DATA_W-1:0] result
);

   localparam int unsigned W     = sms_pkg::DATA_W;
   localparam int unsigned CNT_W = $clog2(W);

   typedef enum logic [1:0] {
      A_IDLE,
      A_DIV,
      A_FIX
   } alu_state_type;

   alu_state_type    state_ff, state_in;
   logic             done_ff, done_in;
   logic [W-1:0]     result_ff, result_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [W-1:0] mag_a, mag_b;
   logic [W:0]   shifted, diff;

   always_comb begin
      mag_a   = a[W-1] ? (W'(0) - a) : a;
      mag_b   = b[W-1] ? (W'(0) - b) : b;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, dvs_ff};

      state_in  = state_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;

      case (state_ff)
         A_IDLE: begin
            if (req.start) begin
               case (req.op)
                  sms_pkg::ALU_ADD: begin
                     result_in = a + b;
                     done_in   = 1'b1;
                  end
                  sms_pkg::ALU_SUB: begin
                     result_in = a - b;
                     done_in   = 1'b1;
                  end
                  sms_pkg::ALU_MUL: begin
                     result_in = W'(a * b);
                     done_in   = 1'b1;
                  end
                  sms_pkg::ALU_DIV: begin
                     quo_in   = mag_a;
                     rem_in   = '0;
                     dvs_in   = mag_b;
                     neg_in   = a[W-1] ^ b[W-1];
                     cnt_in   = CNT_W'(W - 1);
                     state_in = A_DIV;
                  end
                  default: begin
                     result_in = '0;
                     done_in   = 1'b1;
                  end
               endcase
            end
         end
         A_DIV: begin
            // one quotient bit per cycle, remainder stays below the divisor
            if (!diff[W]) begin
               rem_in = diff[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = shifted[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = A_FIX;
            end
         end
         A_FIX: begin
            result_in = neg_ff ? (W'(0) - quo_ff) : quo_ff;
            done_in   = 1'b1;
            state_in  = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      result_ff <= result_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire
